// File: hdl/esm_pkg.sv
package esm_pkg;

  localparam int CMD_W     = 12;
  localparam int SPEED_W   = 11;
  localparam int MAG_W     = 10;
  localparam int SCALE_SH  = 9;
  localparam int FULL_SCALE = 1 << SCALE_SH;
  localparam int DIFF_W    = CMD_W + 1;
  localparam int NUM_W     = 24;
  localparam int CFG_IDX_W = 3;
  localparam int Q_DEPTH   = 2;
  localparam int QPTR_W    = 1;

  typedef logic [CMD_W-1:0] cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NEUTRAL = 3'd0,
    CFG_FWD_MIN = 3'd1,
    CFG_FWD_MAX = 3'd2,
    CFG_REV_MIN = 3'd3,
    CFG_REV_MAX = 3'd4
  } cfg_idx_t;

  localparam cmd_t NEUTRAL_RST = 12'd90;
  localparam cmd_t FWD_MIN_RST = 12'd100;
  localparam cmd_t FWD_MAX_RST = 12'd120;
  localparam cmd_t REV_MIN_RST = 12'd80;
  localparam cmd_t REV_MAX_RST = 12'd60;

  typedef struct packed {
    cmd_t neutral;
    cmd_t fwd_min;
    cmd_t fwd_max;
    cmd_t rev_min;
    cmd_t rev_max;
  } cfg_t;

  // One classified request: the opening word of a brake sequence and the target.
  typedef struct packed {
    cmd_t first_cmd;
    cmd_t target;
    logic brake;
  } q_entry_t;

  function automatic logic in_rev_range(cmd_t c, cmd_t a, cmd_t b);
    return ((c <= a) && (c >= b)) || ((c >= a) && (c <= b));
  endfunction

endpackage

// File: hdl/esm_in_if.sv
interface esm_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [esm_pkg::SPEED_W-1:0]  speed_request;

  modport source (output valid, output speed_request, input ready);
  modport sink (input valid, input speed_request, output ready);
endinterface

// File: hdl/esm_out_if.sv
interface esm_out_if;
  logic          valid;
  logic          ready;
  esm_pkg::cmd_t motor_cmd;
  logic          hold_after;
  logic          braked;
  logic          last;

  modport source (output valid, output motor_cmd, output hold_after, output braked,
                  output last, input ready);
  modport sink (input valid, input motor_cmd, input hold_after, input braked,
                input last, output ready);
endinterface

// File: hdl/esm_front.sv
module esm_front (
  input  logic              clk,
  input  logic              rst_n,
  esm_in_if.sink            in_ch,
  input  esm_pkg::cfg_t     cfg,
  output esm_pkg::q_entry_t push_data,
  output logic              push_valid,
  input  logic              push_ready
);

  logic                                s1_valid_r;
  logic                                s1_valid_nxt;
  esm_pkg::cmd_t                       s1_lo_r;
  logic signed [esm_pkg::NUM_W-1:0]    s1_prod_r;
  logic                                s1_neutral_r;
  esm_pkg::cmd_t                       last_cmd_r;

  logic signed [esm_pkg::SPEED_W-1:0]  spd;
  logic signed [esm_pkg::SPEED_W-1:0]  neg_spd;
  logic                                is_fwd;
  logic                                is_rev;
  logic [esm_pkg::MAG_W-1:0]           mag;
  logic signed [esm_pkg::SPEED_W-1:0]  mag_s;
  esm_pkg::cmd_t                       lo;
  esm_pkg::cmd_t                       hi;
  logic signed [esm_pkg::DIFF_W-1:0]   diff;
  logic signed [esm_pkg::NUM_W-1:0]    prod;
  logic                                in_fire;
  logic                                advance;

  logic signed [esm_pkg::NUM_W-1:0]    num;
  esm_pkg::cmd_t                       target;
  logic                                brake_fwd;
  logic                                brake_rev;

  // Stage 1: pick the range and form (hi - lo) * |speed|.
  always_comb begin
    spd     = in_ch.speed_request;
    neg_spd = -spd;
    is_fwd  = (spd > 0) && (spd <= esm_pkg::SPEED_W'(esm_pkg::FULL_SCALE));
    is_rev  = (spd < 0) && (spd >= -esm_pkg::SPEED_W'(esm_pkg::FULL_SCALE));
    mag     = is_fwd ? spd[esm_pkg::MAG_W-1:0] : neg_spd[esm_pkg::MAG_W-1:0];
    mag_s   = $signed({1'b0, mag});
    lo      = is_fwd ? cfg.fwd_min : cfg.rev_min;
    hi      = is_fwd ? cfg.fwd_max : cfg.rev_max;
    diff    = $signed({1'b0, hi}) - $signed({1'b0, lo});
    prod    = esm_pkg::NUM_W'(diff) * esm_pkg::NUM_W'(mag_s);
  end

  assign in_fire      = in_ch.valid && in_ch.ready;
  assign advance      = s1_valid_r && push_ready;
  assign in_ch.ready  = !s1_valid_r || push_ready;
  assign s1_valid_nxt = in_fire || (s1_valid_r && !push_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_lo_r      <= lo;
      s1_prod_r    <= prod;
      s1_neutral_r <= !(is_fwd || is_rev);
    end
  end

  // Stage 2: finish the interpolation and decide whether a brake sequence is due.
  // The numerator never goes negative, so the floor is a plain shift.
  always_comb begin
    num       = $signed({3'b000, s1_lo_r, {esm_pkg::SCALE_SH{1'b0}}}) + s1_prod_r;
    target    = s1_neutral_r ? cfg.neutral : num[esm_pkg::SCALE_SH +: esm_pkg::CMD_W];
    brake_fwd = (target < cfg.fwd_min) && (last_cmd_r > cfg.fwd_min);
    brake_rev = !esm_pkg::in_rev_range(target, cfg.rev_min, cfg.rev_max) &&
                esm_pkg::in_rev_range(last_cmd_r, cfg.rev_min, cfg.rev_max);
    push_data.target    = target;
    push_data.brake     = brake_fwd || brake_rev;
    push_data.first_cmd = brake_fwd ? cfg.rev_max : cfg.fwd_max;
  end

  assign push_valid = s1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_cmd_r <= esm_pkg::NEUTRAL_RST;
    end else if (advance) begin
      last_cmd_r <= target;
    end
  end

endmodule

// File: hdl/esm_queue.sv
module esm_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  esm_pkg::q_entry_t push_data,
  input  logic              push_valid,
  output logic              push_ready,
  output esm_pkg::q_entry_t pop_data,
  output logic              pop_valid,
  input  logic              pop_ready
);

  esm_pkg::q_entry_t            mem_r [esm_pkg::Q_DEPTH];
  logic [esm_pkg::QPTR_W-1:0]   wr_ptr_r;
  logic [esm_pkg::QPTR_W-1:0]   rd_ptr_r;
  logic [esm_pkg::QPTR_W:0]     count_r;
  logic                         do_push;
  logic                         do_pop;

  assign push_ready = count_r != (esm_pkg::QPTR_W+1)'(esm_pkg::Q_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: hdl/esm_back.sv
module esm_back (
  input  logic              clk,
  input  logic              rst_n,
  input  esm_pkg::cfg_t     cfg,
  input  esm_pkg::q_entry_t pop_data,
  input  logic              pop_valid,
  output logic              pop_ready,
  esm_out_if.source         out_ch
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_NEUTRAL,
    ST_TARGET
  } state_t;

  state_t            state_r;
  esm_pkg::cmd_t     target_r;
  logic              out_valid_r;
  esm_pkg::cmd_t     motor_cmd_r;
  logic              hold_after_r;
  logic              braked_r;
  logic              last_r;
  logic              load;

  // The output register can take a new word when empty or when its word leaves.
  assign load      = !out_valid_r || out_ch.ready;
  assign pop_ready = load && (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else if (load) begin
      case (state_r)
        ST_IDLE: begin
          out_valid_r <= pop_valid;
          if (pop_valid) begin
            target_r <= pop_data.target;
            if (pop_data.brake) begin
              motor_cmd_r  <= pop_data.first_cmd;
              hold_after_r <= 1'b1;
              braked_r     <= 1'b1;
              last_r       <= 1'b0;
              state_r      <= ST_NEUTRAL;
            end else begin
              motor_cmd_r  <= pop_data.target;
              hold_after_r <= 1'b0;
              braked_r     <= 1'b0;
              last_r       <= 1'b1;
            end
          end
        end
        ST_NEUTRAL: begin
          out_valid_r  <= 1'b1;
          motor_cmd_r  <= cfg.neutral;
          hold_after_r <= 1'b1;
          braked_r     <= 1'b1;
          last_r       <= 1'b0;
          state_r      <= ST_TARGET;
        end
        ST_TARGET: begin
          out_valid_r  <= 1'b1;
          motor_cmd_r  <= target_r;
          hold_after_r <= 1'b1;
          braked_r     <= 1'b1;
          last_r       <= 1'b1;
          state_r      <= ST_IDLE;
        end
        default: begin
          out_valid_r <= 1'b0;
          state_r     <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.motor_cmd  = motor_cmd_r;
  assign out_ch.hold_after = hold_after_r;
  assign out_ch.braked     = braked_r;
  assign out_ch.last       = last_r;

endmodule

// File: hdl/esc_speed_mapper_with_brake_top.sv
// Speed mapper for an electronic speed controller, with brake before reverse.
// in_ch carries one signed speed request per word (512 counts per unit); out_ch
// carries motor command words, each flagged with hold_after, braked and last.
// A request gives one word, or three words (full reverse or full forward,
// neutral, target) when the direction changes; last marks the final word.
// The cfg port writes the five command registers; write only while idle.
// The first word of a request reaches out_ch through the product register, a
// queue entry and the output register.
// Throughput: one request per cycle for plain requests while out_ch is ready; a
// brake sequence holds the output register for its three words. A two-entry
// queue sits between the classifier and the output sequencer, so requests keep
// flowing in while a brake sequence drains.
// When the receiver stalls, the output word holds, the queue fills and then
// in_ch.ready drops. Reset restores the default command registers, sets the
// remembered command to neutral and empties the pipeline and queue.
module esc_speed_mapper_with_brake_top (
  input  logic                              clk,
  input  logic                              rst_n,
  esm_in_if.sink                            in_ch,
  esm_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [esm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [esm_pkg::CMD_W-1:0]         cfg_wdata
);

  esm_pkg::cfg_t     cfg_r;
  esm_pkg::q_entry_t push_data;
  logic              push_valid;
  logic              push_ready;
  esm_pkg::q_entry_t pop_data;
  logic              pop_valid;
  logic              pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.neutral <= esm_pkg::NEUTRAL_RST;
      cfg_r.fwd_min <= esm_pkg::FWD_MIN_RST;
      cfg_r.fwd_max <= esm_pkg::FWD_MAX_RST;
      cfg_r.rev_min <= esm_pkg::REV_MIN_RST;
      cfg_r.rev_max <= esm_pkg::REV_MAX_RST;
    end else if (cfg_we) begin
      case (esm_pkg::cfg_idx_t'(cfg_index))
        esm_pkg::CFG_NEUTRAL: cfg_r.neutral <= cfg_wdata;
        esm_pkg::CFG_FWD_MIN: cfg_r.fwd_min <= cfg_wdata;
        esm_pkg::CFG_FWD_MAX: cfg_r.fwd_max <= cfg_wdata;
        esm_pkg::CFG_REV_MIN: cfg_r.rev_min <= cfg_wdata;
        esm_pkg::CFG_REV_MAX: cfg_r.rev_max <= cfg_wdata;
        default: ;
      endcase
    end
  end

  esm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg        (cfg_r),
    .push_data  (push_data),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  esm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_data  (push_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_data   (pop_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  esm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_data  (pop_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .out_ch    (out_ch)
  );

endmodule
